// ----- rtl/dmpd_pkg.sv -----
// dmpd_pkg: shared types and constants of the two-wheel pwm drive
// item structs, register indexes, fixed-point widths, calibration unit state
// no dependencies
package dmpd_pkg;

  localparam int FracBits = 14;
  localparam int DutyW    = 15;
  localparam int SpeedW   = 16;
  localparam int DurW     = 31;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 15;

  // serial multiplier: one multiplier bit per cycle
  localparam int MulN = FracBits + 1;
  localparam int CntW = $clog2(MulN);

  localparam logic [DutyW-1:0] Full = DutyW'(1 << FracBits);

  typedef enum logic {
    OP_DRIVE = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_USE_CAL    = 3'd0,
    CFG_OFFSET_EN  = 3'd1,
    CFG_LEFT_GAIN  = 3'd2,
    CFG_RIGHT_GAIN = 3'd3,
    CFG_LEFT_OFF   = 3'd4,
    CFG_RIGHT_OFF  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    op_e                      op;
    logic signed [SpeedW-1:0] left_speed;
    logic signed [SpeedW-1:0] right_speed;
    logic                     left_brake;
    logic                     right_brake;
    logic [DurW-1:0]          duration_us;
    logic                     end_with_brake;
  } in_item_t;

  typedef struct packed {
    logic [DutyW-1:0] left_pin_f_duty;
    logic [DutyW-1:0] left_pin_r_duty;
    logic [DutyW-1:0] right_pin_f_duty;
    logic [DutyW-1:0] right_pin_r_duty;
    logic             timed_active;
    logic             overlap_warning;
  } out_item_t;

  typedef struct packed {
    logic use_cal;
    logic off_en;
  } cal_cfg_t;

  typedef enum logic [1:0] {
    CAL_IDLE,
    CAL_GAIN,
    CAL_OFF,
    CAL_FIN
  } cal_state_e;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_START,
    TOP_CALC,
    TOP_WAIT
  } top_state_e;

endpackage

// ----- rtl/dmpd_cal.sv -----
// dmpd_cal: per-wheel duty calibration with a bit-serial shift-add multiplier
// gain product, then stall-offset map, then clamp to full
// depends on dmpd_pkg
module dmpd_cal (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  dmpd_pkg::cal_cfg_t            cfg_i,
  input  logic [dmpd_pkg::DutyW-1:0]    mag_i,
  input  logic [dmpd_pkg::DutyW-1:0]    gain_i,
  input  logic [dmpd_pkg::DutyW-1:0]    off_i,
  output logic                          done_o,
  output logic [dmpd_pkg::DutyW-1:0]    duty_o
);

  localparam int W = dmpd_pkg::DutyW;

  dmpd_pkg::cal_state_e state_q, state_d;

  logic [dmpd_pkg::CntW-1:0] cnt_q;
  logic [W-1:0]              a_q;
  logic [dmpd_pkg::MulN-1:0] b_q;
  logic [W-1:0]              acc_q;
  logic                      lo_q;
  logic [W-1:0]              off_q;
  logic [W-1:0]              mag_q;
  logic                      zero_q;
  logic [W-1:0]              duty_q;
  logic                      done_q;

  logic       last;
  logic [W:0] sum;
  logic [W:0] res;
  logic       ld_start, step_en, ld_off, fin;

  // one shift-add step; {acc, lo} holds the product shifted right by the frac bits
  assign sum  = {1'b0, acc_q} + (b_q[0] ? {1'b0, a_q} : '0);
  assign last = (cnt_q == dmpd_pkg::CntW'(dmpd_pkg::MulN - 1));
  assign res  = (cfg_i.use_cal || cfg_i.off_en) ? ({acc_q, lo_q} + {1'b0, off_q})
                                                : {1'b0, a_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dmpd_pkg::CAL_IDLE: if (start_i) state_d = dmpd_pkg::CAL_GAIN;
      dmpd_pkg::CAL_GAIN: if (last) state_d = dmpd_pkg::CAL_OFF;
      dmpd_pkg::CAL_OFF:  if (last) state_d = dmpd_pkg::CAL_FIN;
      dmpd_pkg::CAL_FIN:  state_d = dmpd_pkg::CAL_IDLE;
      default:            state_d = dmpd_pkg::CAL_IDLE;
    endcase
  end

  always_comb begin
    ld_start = 1'b0;
    step_en  = 1'b0;
    ld_off   = 1'b0;
    fin      = 1'b0;
    unique case (state_q)
      dmpd_pkg::CAL_IDLE: ld_start = start_i;
      dmpd_pkg::CAL_GAIN: begin
        step_en = 1'b1;
        ld_off  = last;
      end
      dmpd_pkg::CAL_OFF:  step_en = 1'b1;
      dmpd_pkg::CAL_FIN:  fin = 1'b1;
      default:            ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmpd_pkg::CAL_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_start) begin
      a_q    <= gain_i;
      b_q    <= dmpd_pkg::MulN'(mag_i);
      acc_q  <= '0;
      lo_q   <= 1'b0;
      cnt_q  <= '0;
      mag_q  <= mag_i;
      zero_q <= (mag_i == '0);
      off_q  <= (off_i > dmpd_pkg::Full) ? dmpd_pkg::Full : off_i;
    end else if (ld_off) begin
      // gain result sits in sum at the last step
      a_q   <= cfg_i.use_cal ? sum[W-1:0] : mag_q;
      b_q   <= dmpd_pkg::MulN'(dmpd_pkg::Full - off_q);
      acc_q <= '0;
      lo_q  <= 1'b0;
      cnt_q <= '0;
    end else if (step_en) begin
      acc_q <= sum[W:1];
      lo_q  <= sum[0];
      b_q   <= b_q >> 1;
      cnt_q <= cnt_q + 1'b1;
    end
    if (fin) begin
      if (zero_q) begin
        duty_q <= '0;
      end else if (res > {1'b0, dmpd_pkg::Full}) begin
        duty_q <= dmpd_pkg::Full;
      end else begin
        duty_q <= res[W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign duty_o = duty_q;

endmodule

// ----- rtl/dual_motor_pwm_drive.sv -----
// dual_motor_pwm_drive: two-wheel h-bridge pwm drive with timed actions
// top level: command/tick handling, timer, config registers, output register
// depends on dmpd_pkg and dmpd_cal
//
// usage
// - input channel (in_valid_i / in_ready_o / in_item_i): op drive loads wheel
//   speeds, brake flags and an optional timed duration; op tick counts the
//   microsecond timer down and ends the timed action at zero
// - output channel (out_valid_o / out_ready_i / out_item_o): one item per input
//   item with the four pin duties, timed_active and overlap_warning, all taken
//   from the state after that input item
// - config port (cfg_we_i / cfg_idx_i / cfg_wdata_i): single-cycle writes of
//   calibration enables, gains and stall offsets; write only while idle
// - calculation: the two wheel units each run two bit-serial multiplies (gain,
//   then stall offset) between a start state and a finish state, followed by
//   the done register
// - input: in_ready_o is high only while no item is in calculation, and a new
//   item can be taken while the previous result still waits in the output
//   register
// - receiver stall: a finished result waits inside the calibration units
//   until the output register frees up, and no new item is taken meanwhile
// - reset: config registers go to unity gain, zero offsets, calibration off;
//   speeds, brakes and timer clear; output register empties
module dual_motor_pwm_drive #(
  parameter int TIMER_BITS = 31
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  dmpd_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output dmpd_pkg::out_item_t                out_item_o,
  input  logic                               cfg_we_i,
  input  logic [dmpd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [dmpd_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  localparam int W    = dmpd_pkg::DutyW;
  localparam int CmpW = (TIMER_BITS > dmpd_pkg::DurW) ? TIMER_BITS : dmpd_pkg::DurW;
  localparam logic [CmpW-1:0] TimerMax = CmpW'((64'd1 << TIMER_BITS) - 64'd1);

  typedef struct packed {
    logic         neg;
    logic [W-1:0] mag;
  } speed_t;

  // clamp a signed speed to +/- full and split into sign and magnitude
  function automatic speed_t clamp_speed(input logic signed [dmpd_pkg::SpeedW-1:0] s);
    logic [dmpd_pkg::SpeedW:0] ext;
    logic [dmpd_pkg::SpeedW:0] absv;
    speed_t                    r;
    ext   = {s[dmpd_pkg::SpeedW-1], s};
    absv  = s[dmpd_pkg::SpeedW-1] ? ('0 - ext) : ext;
    r.neg = s[dmpd_pkg::SpeedW-1];
    r.mag = (absv > (dmpd_pkg::SpeedW+1)'(dmpd_pkg::Full)) ? dmpd_pkg::Full : absv[W-1:0];
    return r;
  endfunction

  // configuration registers
  logic         use_cal_q, off_en_q;
  logic [W-1:0] lgain_q, rgain_q, loff_q, roff_q;

  // drive state
  speed_t                lspd_q, rspd_q;
  logic                  lbrk_q, rbrk_q;
  logic [TIMER_BITS-1:0] rem_q;
  logic                  running_q;
  logic                  bae_q;
  logic                  warn_q;

  // output register
  logic                out_valid_q;
  dmpd_pkg::out_item_t out_q, out_d;

  dmpd_pkg::top_state_e state_q, state_d;

  logic                  accept, slot_free, cal_start, out_load;
  logic                  ldone, rdone;
  logic [W-1:0]          lduty, rduty;
  dmpd_pkg::cal_cfg_t    cal_cfg;
  logic [CmpW-1:0]       dur_ext;
  logic [TIMER_BITS-1:0] dur_sat;
  logic [TIMER_BITS-1:0] rem_dec;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  assign dur_ext = CmpW'(in_item_i.duration_us);
  assign dur_sat = (dur_ext > TimerMax) ? TimerMax[TIMER_BITS-1:0]
                                        : dur_ext[TIMER_BITS-1:0];
  assign rem_dec = (rem_q != '0) ? (rem_q - 1'b1) : rem_q;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_cal_q <= 1'b0;
      off_en_q  <= 1'b0;
      lgain_q   <= dmpd_pkg::Full;
      rgain_q   <= dmpd_pkg::Full;
      loff_q    <= '0;
      roff_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dmpd_pkg::CFG_USE_CAL:    use_cal_q <= cfg_wdata_i[0];
        dmpd_pkg::CFG_OFFSET_EN:  off_en_q  <= cfg_wdata_i[0];
        dmpd_pkg::CFG_LEFT_GAIN:  lgain_q   <= cfg_wdata_i[W-1:0];
        dmpd_pkg::CFG_RIGHT_GAIN: rgain_q   <= cfg_wdata_i[W-1:0];
        dmpd_pkg::CFG_LEFT_OFF:   loff_q    <= cfg_wdata_i[W-1:0];
        dmpd_pkg::CFG_RIGHT_OFF:  roff_q    <= cfg_wdata_i[W-1:0];
        default:                  ;
      endcase
    end
  end

  // command and tick handling
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lspd_q    <= '0;
      rspd_q    <= '0;
      lbrk_q    <= 1'b0;
      rbrk_q    <= 1'b0;
      rem_q     <= '0;
      running_q <= 1'b0;
      bae_q     <= 1'b0;
      warn_q    <= 1'b0;
    end else if (accept) begin
      warn_q <= 1'b0;
      if (in_item_i.op == dmpd_pkg::OP_DRIVE) begin
        if (in_item_i.duration_us != '0) begin
          // a timed command on top of a running one restarts the timer
          warn_q    <= running_q;
          running_q <= 1'b1;
          rem_q     <= dur_sat;
          bae_q     <= in_item_i.end_with_brake;
        end
        lbrk_q <= in_item_i.left_brake;
        rbrk_q <= in_item_i.right_brake;
        lspd_q <= in_item_i.left_brake ? '0 : clamp_speed(in_item_i.left_speed);
        rspd_q <= in_item_i.right_brake ? '0 : clamp_speed(in_item_i.right_speed);
      end else if (running_q) begin
        rem_q <= rem_dec;
        if (rem_dec == '0) begin
          // timed action over: stop, or brake both wheels
          lspd_q    <= '0;
          rspd_q    <= '0;
          lbrk_q    <= bae_q;
          rbrk_q    <= bae_q;
          running_q <= 1'b0;
        end
      end
    end
  end

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dmpd_pkg::TOP_IDLE:  if (accept) state_d = dmpd_pkg::TOP_START;
      dmpd_pkg::TOP_START: state_d = dmpd_pkg::TOP_CALC;
      dmpd_pkg::TOP_CALC: begin
        if (ldone) state_d = slot_free ? dmpd_pkg::TOP_IDLE : dmpd_pkg::TOP_WAIT;
      end
      dmpd_pkg::TOP_WAIT:  if (slot_free) state_d = dmpd_pkg::TOP_IDLE;
      default:             state_d = dmpd_pkg::TOP_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready_o = 1'b0;
    cal_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      dmpd_pkg::TOP_IDLE:  in_ready_o = 1'b1;
      dmpd_pkg::TOP_START: cal_start  = 1'b1;
      dmpd_pkg::TOP_CALC:  out_load   = ldone && slot_free;
      dmpd_pkg::TOP_WAIT:  out_load   = slot_free;
      default:             ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dmpd_pkg::TOP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cal_cfg.use_cal = use_cal_q;
  assign cal_cfg.off_en  = off_en_q;

  // both wheels run in lockstep, so the left done marks both
  dmpd_cal u_cal_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cal_start),
    .cfg_i   (cal_cfg),
    .mag_i   (lspd_q.mag),
    .gain_i  (lgain_q),
    .off_i   (loff_q),
    .done_o  (ldone),
    .duty_o  (lduty)
  );

  dmpd_cal u_cal_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cal_start),
    .cfg_i   (cal_cfg),
    .mag_i   (rspd_q.mag),
    .gain_i  (rgain_q),
    .off_i   (roff_q),
    .done_o  (rdone),
    .duty_o  (rduty)
  );

  // pin mapping: brake drives both pins full, negative speed uses the forward pin
  always_comb begin
    out_d.left_pin_f_duty  = lbrk_q ? dmpd_pkg::Full : (lspd_q.neg ? lduty : '0);
    out_d.left_pin_r_duty  = lbrk_q ? dmpd_pkg::Full : (lspd_q.neg ? '0 : lduty);
    out_d.right_pin_f_duty = rbrk_q ? dmpd_pkg::Full : (rspd_q.neg ? rduty : '0);
    out_d.right_pin_r_duty = rbrk_q ? dmpd_pkg::Full : (rspd_q.neg ? '0 : rduty);
    out_d.timed_active     = running_q;
    out_d.overlap_warning  = warn_q;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // the wheel units never get out of step
  a_cal_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ldone == rdone)
    else $error("wheel calibration units out of step");

  // an accepted item blocks further input until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input taken while a calculation runs");

  // a warning only comes with a running timer
  a_warn_timed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_item_o.overlap_warning || out_item_o.timed_active))
    else $error("overlap warning without timed action");

  // one pin driven at a time unless both are at full for braking
  a_left_one_pin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.left_pin_f_duty == '0 || out_item_o.left_pin_r_duty == '0
                     || (out_item_o.left_pin_f_duty == dmpd_pkg::Full
                         && out_item_o.left_pin_r_duty == dmpd_pkg::Full)))
    else $error("left wheel drives both pins");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.left_pin_f_duty <= dmpd_pkg::Full
                     && out_item_o.left_pin_r_duty <= dmpd_pkg::Full
                     && out_item_o.right_pin_f_duty <= dmpd_pkg::Full
                     && out_item_o.right_pin_r_duty <= dmpd_pkg::Full))
    else $error("duty above full scale");

endmodule
